>>> rtl/tbmm_pkg.sv
// Shared types, register codes and fixed-point constants of the missing-mass core.
package tbmm_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PROJECTILE_MASS = 3'd0,
		REG_TARGET_MASS     = 3'd1,
		REG_EJECTILE_MASS   = 3'd2,
		REG_RECOIL_MASS     = 3'd3,
		REG_BEAM_ENERGY     = 3'd4
	} cfg_reg_t;

	// Reset values of the configuration registers (keV)
	localparam logic [24:0] PROJECTILE_MASS_RST = 25'd9327547;
	localparam logic [24:0] TARGET_MASS_RST     = 25'd1875613;
	localparam logic [24:0] EJECTILE_MASS_RST   = 25'd1875613;
	localparam logic [24:0] RECOIL_MASS_RST     = 25'd9327547;
	localparam logic [23:0] BEAM_ENERGY_RST     = 24'd100000;

	// pi in Q30 and one in Q31
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [31:0] Q31_ONE = 32'h8000_0000;

	// Horner divisors and floor(2^32 / k) reciprocals, per series step
	localparam int unsigned HORNER_STEPS = 5;
	localparam logic [6:0] COS_DIV [0:4] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [6:0] SIN_DIV [0:4] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [31:0] COS_RCP [0:4] = '{32'd47721858, 32'd76695844, 32'd143165576,
		32'd357913941, 32'd2147483648};
	localparam logic [31:0] SIN_RCP [0:4] = '{32'd39045157, 32'd59652323, 32'd102261126,
		32'd214748364, 32'd715827882};

	// Square-root stage counts
	localparam int unsigned WIDE_ROOT_BITS   = 52;
	localparam int unsigned NARROW_ROOT_BITS = 28;

	// Cosine delay to line up with the wide root
	localparam int unsigned COS_DELAY = 34;

	// Cosine path side data
	typedef struct packed {
		logic        neg;
		logic        use_sin;
		logic [30:0] x;
		logic [30:0] x2;
	} cos_side_t;

	// Signed cosine magnitude
	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} cos_val_t;

endpackage

>>> rtl/two_body_missing_mass_excitation_core.sv
// Relativistic two-body missing-mass excitation energy, fully pipelined core.
// Pipeline of 89 register stages from the capture of start to done.
// Throughput: one event per clock; busy stays low, so start is taken in every cycle.
// The depth is set by the 52-stage wide square root and the 28-stage result root.
// Reset clears valid bits and loads the register defaults; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module two_body_missing_mass_excitation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        lab_angle,
	input  logic [23:0]        ejectile_energy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [24:0]        cfg_data,
	output logic               done,
	output logic signed [23:0] excitation_energy,
	output logic               unphysical
);

	// Configuration registers
	logic [24:0] projectile_mass_q;
	logic [24:0] target_mass_q;
	logic [24:0] ejectile_mass_q;
	logic [24:0] recoil_mass_q;
	logic [23:0] beam_energy_q;

	// Derived configuration terms
	logic [50:0] pp1_q;
	logic [25:0] e1_q;
	logic [49:0] sq1_q, sq2_q, sq3_q;
	logic [51:0] sqsum_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Write configuration beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			projectile_mass_q <= tbmm_pkg::PROJECTILE_MASS_RST;
			target_mass_q     <= tbmm_pkg::TARGET_MASS_RST;
			ejectile_mass_q   <= tbmm_pkg::EJECTILE_MASS_RST;
			recoil_mass_q     <= tbmm_pkg::RECOIL_MASS_RST;
			beam_energy_q     <= tbmm_pkg::BEAM_ENERGY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tbmm_pkg::REG_PROJECTILE_MASS: projectile_mass_q <= cfg_data;
				tbmm_pkg::REG_TARGET_MASS:     target_mass_q     <= cfg_data;
				tbmm_pkg::REG_EJECTILE_MASS:   ejectile_mass_q   <= cfg_data;
				tbmm_pkg::REG_RECOIL_MASS:     recoil_mass_q     <= cfg_data;
				tbmm_pkg::REG_BEAM_ENERGY:     beam_energy_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Precompute beam momentum squared, beam total energy and mass squares
	always_ff @(posedge clk) begin
		pp1_q   <= 51'(beam_energy_q) *
			51'(27'(beam_energy_q) + {1'b0, projectile_mass_q, 1'b0});
		e1_q    <= 26'(beam_energy_q) + 26'(projectile_mass_q);
		sq1_q   <= 50'(projectile_mass_q) * 50'(projectile_mass_q);
		sq2_q   <= 50'(target_mass_q) * 50'(target_mass_q);
		sq3_q   <= 50'(ejectile_mass_q) * 50'(ejectile_mass_q);
		sqsum_q <= 52'(sq1_q) + 52'(sq2_q) + 52'(sq3_q);
	end

	// ---------------- front stages ----------------
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [15:0] angle_s1;
	logic [23:0] k3_s1, k3_s2;
	logic [14:0] b_s2;
	logic        neg_s2, sin_s2, neg_s3, sin_s3, neg_s4, sin_s4;
	logic [26:0] k3p_s2;
	logic [25:0] e3_s2, e3_s3;
	logic [50:0] pp3_s3;
	logic [46:0] xp_s3;
	logic signed [26:0] d_s3;
	logic [30:0] x_s4, x_s5;
	logic [51:0] ll_s4;
	logic [50:0] lh_s4, hl_s4;
	logic [49:0] hh_s4;
	logic signed [52:0] pm_s4;
	logic [51:0] pe_s4;
	logic [103:0] rad_s5;
	logic signed [55:0] base_s5;
	logic [61:0] x2p_s5;
	logic        neg_s5, sin_s5;

	// Fold the angle into the first octant
	logic [16:0] fold1, fold2;
	logic        fold_sin;
	always_comb begin
		fold1    = angle_s1[15] ? (17'h10000 - {1'b0, angle_s1}) : {1'b0, angle_s1};
		fold_sin = fold1 > 17'd16384;
		fold2    = fold_sin ? (17'd32768 - fold1) : fold1;
	end

	// Signed mass products for stage 4
	logic signed [52:0] m2_ext, d_ext;
	assign m2_ext = 53'($signed({1'b0, target_mass_q}));
	assign d_ext  = 53'(d_s3);

	// Sum of mass terms for stage 5
	logic signed [55:0] pm_ext;
	assign pm_ext = 56'(pm_s4);

	// Advance front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Front payload
	always_ff @(posedge clk) begin
		// capture the beat
		angle_s1 <= lab_angle;
		k3_s1    <= ejectile_energy;
		// fold, ejectile energy sums
		b_s2   <= fold2[14:0];
		neg_s2 <= angle_s1[15];
		sin_s2 <= fold_sin;
		k3_s2  <= k3_s1;
		k3p_s2 <= 27'(k3_s1) + {1'b0, ejectile_mass_q, 1'b0};
		e3_s2  <= 26'(k3_s1) + 26'(ejectile_mass_q);
		// ejectile momentum squared, angle scaling, energy difference
		pp3_s3 <= 51'(k3_s2) * 51'(k3p_s2);
		xp_s3  <= 47'(b_s2) * 47'(tbmm_pkg::PI_Q30);
		d_s3   <= $signed({1'b0, e1_q}) - $signed({1'b0, e3_s2});
		e3_s3  <= e3_s2;
		neg_s3 <= neg_s2;
		sin_s3 <= sin_s2;
		// partial products of p1^2 * p3^2, mass cross terms
		x_s4   <= 31'((xp_s3 + 47'h8000) >> 16);
		ll_s4  <= 52'(pp1_q[25:0]) * 52'(pp3_s3[25:0]);
		lh_s4  <= 51'(pp1_q[25:0]) * 51'(pp3_s3[50:26]);
		hl_s4  <= 51'(pp1_q[50:26]) * 51'(pp3_s3[25:0]);
		hh_s4  <= 50'(pp1_q[50:26]) * 50'(pp3_s3[50:26]);
		pm_s4  <= m2_ext * d_ext;
		pe_s4  <= 52'(e1_q) * 52'(e3_s3);
		neg_s4 <= neg_s3;
		sin_s4 <= sin_s3;
		// merge partials, square the angle
		rad_s5  <= (104'(hh_s4) << 52) + (104'(lh_s4) << 26) + (104'(hl_s4) << 26)
			+ 104'(ll_s4);
		base_s5 <= $signed({4'b0, sqsum_q}) + (pm_ext <<< 1)
			- $signed({3'b0, pe_s4, 1'b0});
		x2p_s5  <= 62'(x_s4) * 62'(x_s4);
		x_s5    <= x_s4;
		neg_s5  <= neg_s4;
		sin_s5  <= sin_s4;
	end

	// ---------------- cosine series ----------------
	tbmm_pkg::cos_side_t side_s6;
	always_ff @(posedge clk) begin
		side_s6.neg     <= neg_s5;
		side_s6.use_sin <= sin_s5;
		side_s6.x       <= x_s5;
		side_s6.x2      <= 31'((x2p_s5 + 62'h4000_0000) >> 31);
	end

	tbmm_pkg::cos_side_t hsa_s [0:4];
	tbmm_pkg::cos_side_t hsb_s [0:4];
	tbmm_pkg::cos_side_t hsc_s [0:4];
	logic [62:0] hp_s [0:4];
	logic [31:0] hv_s [0:4];
	logic [63:0] hq_s [0:4];
	logic [31:0] ht_s [0:4];

	for (genvar i = 0; i < tbmm_pkg::HORNER_STEPS; i++) begin : g_horner
		tbmm_pkg::cos_side_t side_in;
		logic [31:0] t_in;
		logic [6:0]  kb, kc;
		logic [31:0] rcp, vsum, q0, rem, qf;

		if (i == 0) begin : g_first
			assign side_in = side_s6;
			assign t_in    = tbmm_pkg::Q31_ONE;
		end else begin : g_next
			assign side_in = hsc_s[i-1];
			assign t_in    = ht_s[i-1];
		end

		// Pick divisor and reciprocal for the series in use
		always_comb begin
			kb   = hsa_s[i].use_sin ? tbmm_pkg::SIN_DIV[i] : tbmm_pkg::COS_DIV[i];
			rcp  = hsa_s[i].use_sin ? tbmm_pkg::SIN_RCP[i] : tbmm_pkg::COS_RCP[i];
			vsum = 32'((hp_s[i] + 63'h4000_0000) >> 31) + 32'(kb >> 1);
			kc   = hsb_s[i].use_sin ? tbmm_pkg::SIN_DIV[i] : tbmm_pkg::COS_DIV[i];
			q0   = hq_s[i][63:32];
			rem  = hv_s[i] - 32'(q0 * 32'(kc));
			qf   = q0 + 32'(rem >= 32'(kc));
		end

		// Multiply, scale by reciprocal, correct the quotient
		always_ff @(posedge clk) begin
			hp_s[i]  <= 63'(side_in.x2) * 63'(t_in);
			hsa_s[i] <= side_in;
			hv_s[i]  <= vsum;
			hq_s[i]  <= 64'(vsum) * 64'(rcp);
			hsb_s[i] <= hsa_s[i];
			ht_s[i]  <= tbmm_pkg::Q31_ONE - qf;
			hsc_s[i] <= hsb_s[i];
		end
	end

	// Sine needs one more product with x
	logic [62:0] sp_s22;
	logic [31:0] t_s22;
	logic        neg_s22, sin_s22;
	tbmm_pkg::cos_val_t cos_s23;
	tbmm_pkg::cos_val_t cdly_s [0:tbmm_pkg::COS_DELAY-1];

	always_ff @(posedge clk) begin
		sp_s22  <= 63'(hsc_s[tbmm_pkg::HORNER_STEPS-1].x) *
			63'(ht_s[tbmm_pkg::HORNER_STEPS-1]);
		t_s22   <= ht_s[tbmm_pkg::HORNER_STEPS-1];
		neg_s22 <= hsc_s[tbmm_pkg::HORNER_STEPS-1].neg;
		sin_s22 <= hsc_s[tbmm_pkg::HORNER_STEPS-1].use_sin;
		cos_s23.neg <= neg_s22;
		cos_s23.mag <= sin_s22 ? 32'((sp_s22 + 63'h4000_0000) >> 31) : t_s22;
		cdly_s[0]   <= cos_s23;
		for (int j = 1; j < tbmm_pkg::COS_DELAY; j++) begin
			cdly_s[j] <= cdly_s[j-1];
		end
	end

	// ---------------- wide root of p1^2 * p3^2 ----------------
	logic         sq_v_s    [0:tbmm_pkg::WIDE_ROOT_BITS-1];
	logic [103:0] sq_rad_s  [0:tbmm_pkg::WIDE_ROOT_BITS-1];
	logic [53:0]  sq_rem_s  [0:tbmm_pkg::WIDE_ROOT_BITS-1];
	logic [51:0]  sq_root_s [0:tbmm_pkg::WIDE_ROOT_BITS-1];
	logic signed [55:0] sq_base_s [0:tbmm_pkg::WIDE_ROOT_BITS-1];

	for (genvar j = 0; j < tbmm_pkg::WIDE_ROOT_BITS; j++) begin : g_wroot
		logic         v_in;
		logic [103:0] rad_in;
		logic [53:0]  rem_in;
		logic [51:0]  root_in;
		logic signed [55:0] base_in;
		logic [55:0]  sh, dif;
		logic         ge;

		if (j == 0) begin : g_first
			assign v_in    = v_s5;
			assign rad_in  = rad_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign base_in = base_s5;
		end else begin : g_next
			assign v_in    = sq_v_s[j-1];
			assign rad_in  = sq_rad_s[j-1];
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign base_in = sq_base_s[j-1];
		end

		// Trial subtract of 4*root+1
		always_comb begin
			sh  = {rem_in, rad_in[103:102]};
			ge  = sh >= {2'b0, root_in, 2'b01};
			dif = sh - {2'b0, root_in, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else begin
				sq_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_rad_s[j]  <= rad_in << 2;
			sq_rem_s[j]  <= ge ? dif[53:0] : sh[53:0];
			sq_root_s[j] <= {root_in[50:0], ge};
			sq_base_s[j] <= base_in;
		end
	end

	// ---------------- cosine term and squared mass ----------------
	localparam int unsigned WL = tbmm_pkg::WIDE_ROOT_BITS - 1;
	localparam int unsigned CL = tbmm_pkg::COS_DELAY - 1;

	logic        v_s58, v_s59, v_s60;
	logic [63:0] plo_s58;
	logic [51:0] phi_s58;
	logic        neg_s58, neg_s59;
	logic signed [55:0] base_s58, base_s59;
	logic [52:0] mag_s59;
	logic signed [56:0] msq_s60;
	logic [84:0] full;
	logic signed [56:0] term;

	always_comb begin
		full = (85'(phi_s58) << 32) + 85'(plo_s58) + 85'(32'h2000_0000);
		term = neg_s59 ? -$signed({4'b0, mag_s59}) : $signed({4'b0, mag_s59});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s58 <= 1'b0;
			v_s59 <= 1'b0;
			v_s60 <= 1'b0;
		end else begin
			v_s58 <= sq_v_s[WL];
			v_s59 <= v_s58;
			v_s60 <= v_s59;
		end
	end

	always_ff @(posedge clk) begin
		plo_s58  <= 64'(sq_root_s[WL][31:0]) * 64'(cdly_s[CL].mag);
		phi_s58  <= 52'(sq_root_s[WL][51:32]) * 52'(cdly_s[CL].mag);
		neg_s58  <= cdly_s[CL].neg;
		base_s58 <= sq_base_s[WL];
		mag_s59  <= 53'(full >> 30);
		neg_s59  <= neg_s58;
		base_s59 <= base_s58;
		msq_s60  <= 57'(base_s59) + term;
	end

	// ---------------- narrow root of the squared mass ----------------
	logic        nq_v_s    [0:tbmm_pkg::NARROW_ROOT_BITS-1];
	logic        nq_neg_s  [0:tbmm_pkg::NARROW_ROOT_BITS-1];
	logic [55:0] nq_rad_s  [0:tbmm_pkg::NARROW_ROOT_BITS-1];
	logic [29:0] nq_rem_s  [0:tbmm_pkg::NARROW_ROOT_BITS-1];
	logic [27:0] nq_root_s [0:tbmm_pkg::NARROW_ROOT_BITS-1];

	for (genvar j = 0; j < tbmm_pkg::NARROW_ROOT_BITS; j++) begin : g_nroot
		logic        v_in, neg_in;
		logic [55:0] rad_in;
		logic [29:0] rem_in;
		logic [27:0] root_in;
		logic [31:0] sh, dif;
		logic        ge;

		if (j == 0) begin : g_first
			assign v_in    = v_s60;
			assign neg_in  = msq_s60[56];
			assign rad_in  = msq_s60[55:0];
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = nq_v_s[j-1];
			assign neg_in  = nq_neg_s[j-1];
			assign rad_in  = nq_rad_s[j-1];
			assign rem_in  = nq_rem_s[j-1];
			assign root_in = nq_root_s[j-1];
		end

		// Trial subtract of 4*root+1
		always_comb begin
			sh  = {rem_in, rad_in[55:54]};
			ge  = sh >= {2'b0, root_in, 2'b01};
			dif = sh - {2'b0, root_in, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nq_v_s[j] <= 1'b0;
			end else begin
				nq_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			nq_neg_s[j]  <= neg_in;
			nq_rad_s[j]  <= rad_in << 2;
			nq_rem_s[j]  <= ge ? dif[29:0] : sh[29:0];
			nq_root_s[j] <= {root_in[26:0], ge};
		end
	end

	// ---------------- round, subtract recoil mass, saturate ----------------
	localparam int unsigned NL = tbmm_pkg::NARROW_ROOT_BITS - 1;

	logic [28:0]        root_rnd;
	logic signed [30:0] ex_full;
	logic signed [23:0] ex_sat;

	always_comb begin
		root_rnd = 29'(nq_root_s[NL]) + 29'(nq_rem_s[NL] > 30'(nq_root_s[NL]));
		ex_full  = $signed({2'b0, root_rnd}) - $signed({6'b0, recoil_mass_q});
		if (ex_full > 31'sd8388607) begin
			ex_sat = 24'sh7F_FFFF;
		end else if (ex_full < -31'sd8388608) begin
			ex_sat = 24'sh80_0000;
		end else begin
			ex_sat = ex_full[23:0];
		end
	end

	// Output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= nq_v_s[NL];
		end
	end

	always_ff @(posedge clk) begin
		excitation_energy <= nq_neg_s[NL] ? 24'sd0 : ex_sat;
		unphysical        <= nq_neg_s[NL];
	end

endmodule
